// ----- design/huffman_table_encoder_packer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman table encoder and packer
// Concurrent property checks; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HTEP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("htep assertion failed");
// next-cycle implication
`define HTEP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("htep assertion failed");
`else
`define HTEP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HTEP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/htep_pkg.sv -----
// ----------------------------------------------------------------------------
// htep_pkg
// Shared codes, types and constants of the Huffman encoder and bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htep_pkg;

	localparam int BYTE_BITS = 8;
	localparam int PEND_W    = BYTE_BITS - 1;
	localparam int CNT_W     = 3;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_FLUSH  = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT
	} pack_state_t;

	typedef struct packed {
		logic encode;
		logic flush;
	} pack_cmd_t;

endpackage

`default_nettype wire

// ----- design/htep_req_if.sv -----
// ----------------------------------------------------------------------------
// htep_req_if
// Request channel: load, encode or flush items with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface htep_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  symbol;
	logic [31:0] code_word;
	logic [5:0]  code_length;

	modport source (output valid, req_type, symbol, code_word, code_length, input ready);
	modport sink   (input valid, req_type, symbol, code_word, code_length, output ready);
endinterface

`default_nettype wire

// ----- design/htep_byte_if.sv -----
// ----------------------------------------------------------------------------
// htep_byte_if
// Output channel: one packed byte per transfer with a last-of-request flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface htep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;

	modport source (output valid, out_byte, is_last, input ready);
	modport sink   (input valid, out_byte, is_last, output ready);
endinterface

`default_nettype wire

// ----- design/huffman_table_encoder_packer.sv -----
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer
// Byte-symbol Huffman encoder with a loadable code table and bit packer.
// ----------------------------------------------------------------------------
// Usage:
//  req   : valid/ready request channel. req_type selects load (write one
//          symbol's code word and length), encode (append the symbol's code
//          bits, first bit most significant) or flush (pad the partial byte
//          with zeros and emit it). Unused codes and out-of-table symbols
//          are taken and dropped.
//  bytes : valid/ready byte channel; is_last marks the final byte of an item.
//  Sequencing: an encode makes N output bytes (0 to 4): a table read, a merge
//  of the code into the accumulator, then one byte per cycle through the
//  shared extract shifter while bytes is not stalled. A flush with bits
//  pending goes straight to the shifter and emits one byte.
//  req.ready is high only while the sequencer is idle; the last byte may
//  still wait in the output register while the next item is taken.
//  A stall on bytes holds the output register and the sequencer.
//  Reset clears all code lengths (unloaded symbols emit nothing), the
//  partial byte and the output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_table_encoder_packer #(
	parameter int SYMBOL_COUNT  = 256,
	parameter int MAX_CODE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	htep_req_if.sink     req,
	htep_byte_if.source  bytes
);
	import htep_pkg::*;

	localparam int IDX_W = $clog2(SYMBOL_COUNT);
	localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

	logic                     idle;
	logic                     accept;
	logic                     in_range;
	logic                     wr_en;
	logic                     rd_en;
	logic [LEN_W-1:0]         len_sat;
	logic [MAX_CODE_BITS-1:0] rd_word;
	logic [LEN_W-1:0]         rd_len;
	pack_cmd_t                cmd;

	assign req.ready = idle;
	assign accept    = req.valid && idle;
	assign in_range  = {1'b0, req.symbol} < 9'(SYMBOL_COUNT);

	// saturate over-long lengths at load
	assign len_sat = (req.code_length > 6'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
		: LEN_W'(req.code_length);

	always_comb begin
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		cmd.encode = 1'b0;
		cmd.flush  = 1'b0;
		if (accept) begin
			unique case (req_code_t'(req.req_type))
				REQ_LOAD:   wr_en = in_range;
				REQ_ENCODE: begin
					rd_en      = in_range;
					cmd.encode = in_range;
				end
				REQ_FLUSH:  cmd.flush = 1'b1;
				default: ;
			endcase
		end
	end

	htep_table #(
		.SYMBOL_COUNT  (SYMBOL_COUNT),
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.IDX_W         (IDX_W),
		.LEN_W         (LEN_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (req.symbol[IDX_W-1:0]),
		.wr_word (req.code_word[MAX_CODE_BITS-1:0]),
		.wr_len  (len_sat),
		.rd_en   (rd_en),
		.rd_addr (req.symbol[IDX_W-1:0]),
		.rd_word (rd_word),
		.rd_len  (rd_len)
	);

	htep_packer #(
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.LEN_W         (LEN_W)
	) u_packer (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.idle    (idle),
		.rd_word (rd_word),
		.rd_len  (rd_len),
		.bytes   (bytes)
	);

endmodule

`default_nettype wire

// ----- design/htep_table.sv -----
// ----------------------------------------------------------------------------
// htep_table
// Code word and code length store, one write port and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htep_table #(
	parameter int SYMBOL_COUNT  = 256,
	parameter int MAX_CODE_BITS = 32,
	parameter int IDX_W         = $clog2(SYMBOL_COUNT),
	parameter int LEN_W         = $clog2(MAX_CODE_BITS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_addr,
	input  logic [MAX_CODE_BITS-1:0] wr_word,
	input  logic [LEN_W-1:0]         wr_len,
	input  logic                     rd_en,
	input  logic [IDX_W-1:0]         rd_addr,
	output logic [MAX_CODE_BITS-1:0] rd_word,
	output logic [LEN_W-1:0]         rd_len
);

	logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
	logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0]  valid_q;
	logic [MAX_CODE_BITS-1:0] word_rd_q;
	logic [LEN_W-1:0]         len_rd_q;
	logic                     valid_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_mem[wr_addr] <= wr_word;
			len_mem[wr_addr]  <= wr_len;
		end
		if (rd_en) begin
			word_rd_q <= code_mem[rd_addr];
			len_rd_q  <= len_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				valid_rd_q <= valid_q[rd_addr];
		end
	end

	// an entry never loaded has length zero
	assign rd_len  = valid_rd_q ? len_rd_q : '0;
	assign rd_word = word_rd_q;

endmodule

`default_nettype wire

// ----- design/htep_packer.sv -----
// ----------------------------------------------------------------------------
// htep_packer
// Bit accumulator with a shared byte extract shifter under a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_table_encoder_packer_assert.svh"

module htep_packer #(
	parameter int MAX_CODE_BITS = 32,
	parameter int LEN_W         = $clog2(MAX_CODE_BITS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  htep_pkg::pack_cmd_t      cmd,
	output logic                     idle,
	input  logic [MAX_CODE_BITS-1:0] rd_word,
	input  logic [LEN_W-1:0]         rd_len,
	htep_byte_if.source              bytes
);
	import htep_pkg::*;

	localparam int ACC_W = MAX_CODE_BITS + PEND_W;
	localparam int TOT_W = $clog2(ACC_W + 1);

	pack_state_t              state_q, state_d;
	logic [ACC_W-1:0]         acc_q;
	logic [TOT_W-1:0]         total_q;
	logic [PEND_W-1:0]        pending_q;
	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	logic [BYTE_BITS-1:0]     out_byte_q;
	logic                     is_last_q;

	logic [MAX_CODE_BITS-1:0] code_mask;
	logic [ACC_W-1:0]         acc_n;
	logic [TOT_W-1:0]         tot_n;
	logic [ACC_W-1:0]         acc_flush;
	logic [TOT_W-1:0]         rem;
	logic [ACC_W-1:0]         acc_sh;
	logic                     slot_free;
	logic                     load_out;

	function automatic logic [PEND_W-1:0] pend_mask(input logic [CNT_W-1:0] n);
		pend_mask = ~({PEND_W{1'b1}} << n);
	endfunction

	assign code_mask = ~({MAX_CODE_BITS{1'b1}} << rd_len);
	assign acc_n     = (ACC_W'(pending_q) << rd_len) | ACC_W'(rd_word & code_mask);
	assign tot_n     = TOT_W'(count_q) + TOT_W'(rd_len);
	assign acc_flush = ACC_W'(pending_q) << (4'(BYTE_BITS) - {1'b0, count_q});
	assign rem       = total_q - TOT_W'(BYTE_BITS);
	assign acc_sh    = acc_q >> rem;
	assign slot_free = !out_valid_q || bytes.ready;
	assign idle      = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.encode)
					state_d = ST_LOOKUP;
				else if (cmd.flush && count_q != '0)
					state_d = ST_EMIT;
			end
			ST_LOOKUP: begin
				state_d = (tot_n >= TOT_W'(BYTE_BITS)) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (rem < TOT_W'(BYTE_BITS))
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.flush && count_q != '0) begin
			acc_q   <= acc_flush;
			total_q <= TOT_W'(BYTE_BITS);
		end else if (state_q == ST_LOOKUP) begin
			acc_q   <= acc_n;
			total_q <= tot_n;
		end else if (load_out) begin
			total_q <= rem;
		end
	end

	// leftover bits below the emitted bytes become the new partial byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			count_q   <= '0;
		end else if (state_q == ST_LOOKUP && tot_n < TOT_W'(BYTE_BITS)) begin
			pending_q <= acc_n[PEND_W-1:0] & pend_mask(tot_n[CNT_W-1:0]);
			count_q   <= tot_n[CNT_W-1:0];
		end else if (load_out && rem < TOT_W'(BYTE_BITS)) begin
			pending_q <= acc_q[PEND_W-1:0] & pend_mask(rem[CNT_W-1:0]);
			count_q   <= rem[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (bytes.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte_q <= acc_sh[BYTE_BITS-1:0];
			is_last_q  <= (rem < TOT_W'(BYTE_BITS));
		end
	end

	assign bytes.valid    = out_valid_q;
	assign bytes.out_byte = out_byte_q;
	assign bytes.is_last  = is_last_q;

	`HTEP_ASSERT_IMP(a_emit_has_byte, clk, arst_n, state_q == ST_EMIT,
		total_q >= TOT_W'(BYTE_BITS))
	`HTEP_ASSERT_NXT(a_encode_looks_up, clk, arst_n, state_q == ST_IDLE && cmd.encode,
		state_q == ST_LOOKUP)
	`HTEP_ASSERT_NXT(a_last_ends_item, clk, arst_n, load_out && rem < TOT_W'(BYTE_BITS),
		state_q == ST_IDLE && out_valid_q && is_last_q)
	`HTEP_ASSERT_NXT(a_empty_flush, clk, arst_n,
		state_q == ST_IDLE && !cmd.encode && cmd.flush && count_q == '0,
		state_q == ST_IDLE && count_q == '0)

endmodule

`default_nettype wire

// ----- tb/htep_byte_checker.sv -----
// ----------------------------------------------------------------------------
// htep_byte_checker
// Watches the request and byte channels of the Huffman encoder and packer,
// predicts the packed bytes of every accepted request and compares them in
// order with the bytes that the block hands out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htep_byte_checker (
	input  logic clk,
	input  logic arst_n,
	htep_req_if  req,
	htep_byte_if bytes,
	output int   errors,
	output int   outstanding
);
	import htep_pkg::*;

	localparam int SYMBOLS  = 256;
	localparam int MAX_BITS = 32;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} coded_byte_t;

	coded_byte_t expected_bytes[$];

	logic [31:0] code_words   [SYMBOLS];
	logic [5:0]  code_lengths [SYMBOLS];
	logic [6:0]  partial_bits;
	logic [2:0]  partial_count;

	task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
		errors++;
		$error("%s: expected %0h, got %0h", field, want, got);
	endtask

	// Update the table and the partial byte; queue the bytes this request emits.
	task automatic pack_request(input logic [1:0] kind, input logic [7:0] sym,
			input logic [31:0] word, input logic [5:0] len);
		logic [38:0] acc;
		logic [63:0] word_mask;
		logic [7:0]  rem_mask;
		coded_byte_t item;
		int          used;
		int          total;
		int          nbytes;
		if (kind == REQ_LOAD) begin
			used = (len > MAX_BITS) ? MAX_BITS : len;
			word_mask = (64'd1 << used) - 64'd1;
			code_lengths[sym] = 6'(used);
			code_words[sym] = word & word_mask[31:0];
		end else if (kind == REQ_ENCODE) begin
			used = code_lengths[sym];
			acc = (39'(partial_bits) << used) | 39'(code_words[sym]);
			total = partial_count + used;
			nbytes = total / BYTE_BITS;
			for (int i = 0; i < nbytes; i++) begin
				total -= BYTE_BITS;
				item.data = 8'(acc >> total);
				item.last = (i == nbytes - 1);
				expected_bytes.push_back(item);
			end
			rem_mask = (8'd1 << total) - 8'd1;
			partial_bits = acc[6:0] & rem_mask[6:0];
			partial_count = 3'(total);
		end else if (kind == REQ_FLUSH && partial_count != 0) begin
			// pad with zeros on the right
			item.data = {1'b0, partial_bits} << (4'd8 - partial_count);
			item.last = 1'b1;
			expected_bytes.push_back(item);
			partial_bits = '0;
			partial_count = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		coded_byte_t want;
		if (!arst_n) begin
			foreach (code_lengths[i]) begin
				code_lengths[i] = '0;
				code_words[i] = '0;
			end
			partial_bits = '0;
			partial_count = '0;
			expected_bytes.delete();
			errors = 0;
		end else begin
			// retire the byte first: it can never belong to a request taken at this edge
			if (bytes.valid && bytes.ready) begin
				if (expected_bytes.size() == 0) begin
					errors++;
					$error("out_byte: no byte expected, got %0h", bytes.out_byte);
				end else begin
					want = expected_bytes.pop_front();
					if (bytes.out_byte !== want.data)
						report("out_byte", want.data, bytes.out_byte);
					if (bytes.is_last !== want.last)
						report("is_last", 8'(want.last), 8'(bytes.is_last));
				end
			end
			if (req.valid && req.ready)
				pack_request(req.req_type, req.symbol, req.code_word, req.code_length);
		end
		outstanding = expected_bytes.size();
	end

endmodule

// ----- tb/huffman_table_encoder_packer_test.sv -----
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer_test
// Drives load, encode and flush requests into the encoder: a directed set of
// corner cases, then random traffic in phases with and without idle cycles
// on either channel and one long output hold-off. Checking is done by
// htep_byte_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_table_encoder_packer_test;
	import htep_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 15;
	localparam int DRAIN_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   hold_left;
	int   errors;
	int   outstanding;
	bit   loaded [256];
	logic [7:0] loaded_syms[$];

	htep_req_if  req_ch ();
	htep_byte_if byte_ch ();

	huffman_table_encoder_packer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.bytes  (byte_ch)
	);

	htep_byte_checker i_byte_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.bytes       (byte_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// Output side: random stalls, or a long hold-off while hold_left runs down.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			byte_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			byte_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
			input logic [31:0] word, input logic [5:0] len);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.symbol      <= sym;
		req_ch.code_word   <= word;
		req_ch.code_length <= len;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic load_entry(input logic [7:0] sym, input logic [31:0] word,
			input logic [5:0] len);
		send_item(REQ_LOAD, sym, word, len);
		if (!loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	task automatic random_item();
		int         roll;
		logic [7:0] sym;
		logic [5:0] len;
		roll = $urandom_range(99);
		len = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 32));
		if (roll < 18 || loaded_syms.size() == 0) begin
			load_entry(8'($urandom_range(255)), $urandom, len);
		end else if (roll < 88) begin
			// mostly loaded symbols; stray ones exercise empty entries
			if ($urandom_range(9) != 0)
				sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
			else
				sym = 8'($urandom_range(255));
			send_item(REQ_ENCODE, sym, $urandom, len);
		end else if (roll < 97) begin
			send_item(REQ_FLUSH, 8'($urandom_range(255)), $urandom, len);
		end else begin
			send_item(REQ_UNUSED, 8'($urandom_range(255)), $urandom, len);
		end
	endtask

	task automatic run_phase(input int sender_idle, input int receiver_stall);
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		repeat (PHASE_ITEMS) random_item();
	endtask

	initial begin
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.symbol = '0;
		req_ch.code_word = '0;
		req_ch.code_length = '0;
		byte_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed corner cases
		load_entry(8'd0, 32'hDEAD_BEEF, 6'd0);
		load_entry(8'd255, 32'hFFFF_FFFF, 6'd32);
		load_entry(8'd1, 32'h0000_0001, 6'd1);
		load_entry(8'd2, 32'hFFFF_FF55, 6'd7);   // drop bits above the length
		load_entry(8'd3, 32'hA5A5_A5A5, 6'd63);  // saturate the length
		load_entry(8'd4, 32'h1234_5678, 6'd33);
		load_entry(8'd5, 32'h0000_00C3, 6'd8);
		load_entry(8'd6, 32'h0000_0000, 6'd32);
		send_item(REQ_FLUSH, 8'd0, 32'd0, 6'd0);    // nothing pending
		send_item(REQ_ENCODE, 8'd255, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd1, 32'd0, 6'd0);
		send_item(REQ_FLUSH, 8'd0, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd2, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd255, 32'd0, 6'd0); // seven pending plus 32 bits
		send_item(REQ_FLUSH, 8'd0, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
		send_item(REQ_ENCODE, 8'd200, 32'd0, 6'd0); // never loaded
		send_item(REQ_UNUSED, 8'd1, 32'hFFFF_FFFF, 6'd32);
		send_item(REQ_ENCODE, 8'd1, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd3, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd4, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd5, 32'd0, 6'd0);
		send_item(REQ_ENCODE, 8'd6, 32'd0, 6'd0);
		send_item(REQ_FLUSH, 8'd0, 32'd0, 6'd0);
		load_entry(8'd1, 32'hFFFF_FFFF, 6'd0);
		send_item(REQ_ENCODE, 8'd1, 32'd0, 6'd0);

		run_phase(0, 0);
		run_phase(53, 0);
		run_phase(0, 53);
		run_phase(32, 32);

		// hold the output long enough for the block to back up its input
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		repeat (PHASE_ITEMS) random_item();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("** huffman_table_encoder_packer: PASSED **");
		else
			$display("** huffman_table_encoder_packer: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** huffman_table_encoder_packer: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/htep_pkg.sv
design/htep_req_if.sv
design/htep_byte_if.sv
design/htep_table.sv
design/htep_packer.sv
design/huffman_table_encoder_packer.sv
tb/htep_byte_checker.sv
tb/huffman_table_encoder_packer_test.sv
